@@ rtl/umps_pkg.sv @@
// Shared types and constants for the masked pattern scanner.
// No dependencies; every other file imports this package.
package umps_pkg;

    localparam int MAX_PATTERN      = 16;
    localparam int SEGMENT_TAG_BITS = 3;

    localparam int IDX_W  = $clog2(MAX_PATTERN);
    localparam int LEN_W  = $clog2(MAX_PATTERN + 1);
    localparam int WORD_W = 32;
    localparam int WS_W   = 31;
    localparam int TAG_W  = 3;
    localparam int CNT_W  = 2;

    // APB: two 32-bit registers at byte offsets 0 and 4
    localparam int NUM_REGS = 2;
    localparam int PADDR_W  = $clog2(NUM_REGS) + 2;
    localparam int REG_IDX_W = PADDR_W - 2;

    localparam logic [REG_IDX_W-1:0] REG_PATTERN_LENGTH = REG_IDX_W'(0);
    localparam logic [REG_IDX_W-1:0] REG_START_ADDRESS  = REG_IDX_W'(1);

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_WORD = 1'b1;

    localparam logic [CNT_W-1:0] HITS_SAT = CNT_W'(2);

    // one past the highest byte address
    localparam logic [WORD_W+1:0] ADDR_END_MAX = (WORD_W+2)'(1) << WORD_W;

    typedef logic [WORD_W-1:0]           t_word;
    typedef logic [SEGMENT_TAG_BITS-1:0] t_tag;

    typedef enum logic [1:0] {
        ST_UNIQUE  = 2'd0,
        ST_NONE    = 2'd1,
        ST_MULTI   = 2'd2,
        ST_INVALID = 2'd3
    } t_status;

    typedef struct packed {
        logic             cmd;
        logic [IDX_W-1:0] entry_index;
        t_word            pattern_word;
        t_word            pattern_mask;
        t_word            data_word;
        logic             word_mapped;
        logic [TAG_W-1:0] segment_tag;
        logic             last;
    } t_scan_req;

endpackage

@@ rtl/umps_if.sv @@
// Valid/ready channel interfaces for scanner requests and results.
// Depends on umps_pkg.
interface umps_in_if import umps_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             cmd;
    logic [IDX_W-1:0] entry_index;
    t_word            pattern_word;
    t_word            pattern_mask;
    t_word            data_word;
    logic             word_mapped;
    logic [TAG_W-1:0] segment_tag;
    logic             last;

    modport source (
        output valid, cmd, entry_index, pattern_word, pattern_mask,
               data_word, word_mapped, segment_tag, last,
        input  ready
    );
    modport sink (
        input  valid, cmd, entry_index, pattern_word, pattern_mask,
               data_word, word_mapped, segment_tag, last,
        output ready
    );
endinterface

interface umps_out_if import umps_pkg::*; ();
    logic             valid;
    logic             ready;
    t_status          status;
    t_word            match_address;
    logic [CNT_W-1:0] hit_total;

    modport source (output valid, status, match_address, hit_total, input ready);
    modport sink   (input valid, status, match_address, hit_total, output ready);
endinterface

@@ rtl/umps_window_match.sv @@
// Parallel masked compare of the sliding window against the pattern.
// Depends on umps_pkg. Purely combinational.
module umps_window_match import umps_pkg::*; (
    input  logic [LEN_W-1:0] i_len,
    input  t_word            i_win_word   [MAX_PATTERN],
    input  logic             i_win_mapped [MAX_PATTERN],
    input  t_tag             i_win_tag    [MAX_PATTERN],
    input  t_word            i_pat_word   [MAX_PATTERN],
    input  t_word            i_pat_mask   [MAX_PATTERN],
    output logic             o_match
);

    logic [MAX_PATTERN-1:0] lane_ok;
    logic [MAX_PATTERN-1:0] word_ok;

    for (genvar g = 0; g < MAX_PATTERN; g++) begin : g_lane
        logic             in_use;
        logic [LEN_W-1:0] pos;
        logic [IDX_W-1:0] sel;

        assign in_use = LEN_W'(g) < i_len;

        // window slot g: mapped and same segment as the newest word
        assign lane_ok[g] = !in_use ||
                            (i_win_mapped[g] && (i_win_tag[g] == i_win_tag[0]));

        // pattern entry g lines up with the word len-1-g steps back
        assign pos = i_len - LEN_W'(1) - LEN_W'(g);
        assign sel = pos[IDX_W-1:0];
        assign word_ok[g] = !in_use ||
                            (((i_win_word[sel] ^ i_pat_word[g]) & i_pat_mask[g]) == '0);
    end

    assign o_match = (&lane_ok) && (&word_ok);

endmodule

@@ rtl/unique_masked_pattern_scanner.sv @@
// Masked signature scanner top level: APB registers, request stage,
// window shift line, hit tracking and result register.
// Depends on umps_pkg, umps_if and umps_window_match.

// Throughput is one request per cycle, loads and memory words alike, unless
// the input side stalls. A request is captured in an input register; from
// there a memory word is shifted into the 16-deep window, the masked compare
// of all pattern positions runs in parallel and the hit count is updated, and
// a scan's final word loads the result register. The input side stalls only
// when a final word meets a result that has not been taken yet. The user is
// bound to write pattern_length and start_address over APB only between
// requests; the block itself does not enforce this. Pattern entries are loaded
// through the request channel and must be loaded before a scan uses them.
module unique_masked_pattern_scanner import umps_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    umps_in_if.sink            i_in,
    umps_out_if.source         o_out
);

    // configuration
    logic [LEN_W-1:0]     r_len;
    t_word                r_start;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 cfg_wr;

    // request stage
    logic      r_req_valid;
    t_scan_req r_req;
    logic      adv;

    // scan state
    t_word            r_pat_word [MAX_PATTERN];
    t_word            r_pat_mask [MAX_PATTERN];
    t_word            r_win_word   [MAX_PATTERN];
    logic             r_win_mapped [MAX_PATTERN];
    t_tag             r_win_tag    [MAX_PATTERN];
    t_word            n_win_word   [MAX_PATTERN];
    logic             n_win_mapped [MAX_PATTERN];
    t_tag             n_win_tag    [MAX_PATTERN];
    logic [WS_W-1:0]  r_ws, n_ws;
    logic [CNT_W-1:0] r_hits, n_hits;
    t_word            r_first, n_first;

    // result register
    logic             r_out_valid;
    t_status          r_status, n_status;
    t_word            r_addr, n_addr;
    logic [CNT_W-1:0] r_hit_total;

    logic             len_ok;
    logic             enough;
    logic [WORD_W+1:0] end_addr;
    t_word            base;
    logic             win_match;
    logic             hit;
    logic             is_word;
    logic             is_final;

    // ---------------- APB ----------------
    assign reg_idx = paddr[PADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_comb begin
        unique case (reg_idx)
            REG_PATTERN_LENGTH: prdata = 32'(r_len);
            REG_START_ADDRESS:  prdata = r_start;
            default:            prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len   <= '0;
            r_start <= '0;
        end else if (cfg_wr) begin
            if (reg_idx == REG_PATTERN_LENGTH) begin
                r_len <= pwdata[LEN_W-1:0];
            end
            if (reg_idx == REG_START_ADDRESS) begin
                r_start <= pwdata;
            end
        end
    end

    // ---------------- request stage ----------------
    assign is_word  = r_req.cmd == CMD_WORD;
    assign is_final = is_word && r_req.last;
    assign adv = r_req_valid && (!is_final || !r_out_valid || o_out.ready);
    assign i_in.ready = !r_req_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_req_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_req.cmd          <= i_in.cmd;
            r_req.entry_index  <= i_in.entry_index;
            r_req.pattern_word <= i_in.pattern_word;
            r_req.pattern_mask <= i_in.pattern_mask;
            r_req.data_word    <= i_in.data_word;
            r_req.word_mapped  <= i_in.word_mapped;
            r_req.segment_tag  <= i_in.segment_tag;
            r_req.last         <= i_in.last;
        end
    end

    // pattern store, no reset: an unwritten entry only affects a scan whose pattern length covers it
    always_ff @(posedge i_clk) begin
        if (adv && !is_word) begin
            r_pat_word[r_req.entry_index] <= r_req.pattern_word;
            r_pat_mask[r_req.entry_index] <= r_req.pattern_mask;
        end
    end

    // ---------------- window compare ----------------
    always_comb begin
        n_win_word[0]   = r_req.data_word;
        n_win_mapped[0] = r_req.word_mapped;
        n_win_tag[0]    = r_req.segment_tag[SEGMENT_TAG_BITS-1:0];
        for (int k = 1; k < MAX_PATTERN; k++) begin
            n_win_word[k]   = r_win_word[k-1];
            n_win_mapped[k] = r_win_mapped[k-1];
            n_win_tag[k]    = r_win_tag[k-1];
        end
    end

    assign n_ws = (r_ws == '1) ? r_ws : r_ws + WS_W'(1);

    umps_window_match u_match (
        .i_len        (r_len),
        .i_win_word   (n_win_word),
        .i_win_mapped (n_win_mapped),
        .i_win_tag    (n_win_tag),
        .i_pat_word   (r_pat_word),
        .i_pat_mask   (r_pat_mask),
        .o_match      (win_match)
    );

    assign len_ok = (r_len != '0) && (r_len <= LEN_W'(MAX_PATTERN));
    assign enough = n_ws >= WS_W'(r_len);

    // end of window in bytes = start + 4*words_seen; must not pass the top
    assign end_addr = {2'b00, r_start} + {1'b0, n_ws, 2'b00};
    assign base     = end_addr[WORD_W-1:0] - WORD_W'({r_len, 2'b00});
    assign hit      = len_ok && enough && (end_addr <= ADDR_END_MAX) && win_match;

    always_comb begin
        n_hits  = r_hits;
        n_first = r_first;
        if (hit) begin
            if (r_hits == '0) begin
                n_first = base;
            end
            if (r_hits != HITS_SAT) begin
                n_hits = r_hits + CNT_W'(1);
            end
        end
    end

    always_comb begin
        n_addr = '0;
        priority if (!len_ok || !enough) begin
            n_status = ST_INVALID;
        end else if (n_hits == CNT_W'(1)) begin
            n_status = ST_UNIQUE;
            n_addr   = n_first;
        end else if (n_hits == '0) begin
            n_status = ST_NONE;
        end else begin
            n_status = ST_MULTI;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ws    <= '0;
            r_hits  <= '0;
            r_first <= '0;
            for (int k = 0; k < MAX_PATTERN; k++) begin
                r_win_word[k]   <= '0;
                r_win_mapped[k] <= 1'b0;
                r_win_tag[k]    <= '0;
            end
        end else if (adv && is_word) begin
            if (r_req.last) begin
                r_ws    <= '0;
                r_hits  <= '0;
                r_first <= '0;
                for (int k = 0; k < MAX_PATTERN; k++) begin
                    r_win_word[k]   <= '0;
                    r_win_mapped[k] <= 1'b0;
                    r_win_tag[k]    <= '0;
                end
            end else begin
                r_ws    <= n_ws;
                r_hits  <= n_hits;
                r_first <= n_first;
                for (int k = 0; k < MAX_PATTERN; k++) begin
                    r_win_word[k]   <= n_win_word[k];
                    r_win_mapped[k] <= n_win_mapped[k];
                    r_win_tag[k]    <= n_win_tag[k];
                end
            end
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv && is_final) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && is_final) begin
            r_status    <= n_status;
            r_addr      <= n_addr;
            r_hit_total <= n_hits;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.status        = r_status;
    assign o_out.match_address = r_addr;
    assign o_out.hit_total     = r_hit_total;

endmodule

@@ rtl/umps_checker.sv @@
// Port-level checker for the scanner, bound to the top level.
// Depends on umps_pkg.
module umps_checker import umps_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_ready,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input t_status          i_status,
    input t_word            i_match_address,
    input logic [CNT_W-1:0] i_hit_total
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_status) && $stable(i_match_address)
            && $stable(i_hit_total))
        else $error("result changed while stalled");

    // hit count agrees with the reported status; an invalid report carries
    // whatever count the scan reached (length may change mid-scan)
    a_status_hits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |->
            (i_status == ST_UNIQUE  && i_hit_total == CNT_W'(1)) ||
            (i_status == ST_NONE    && i_hit_total == '0) ||
            (i_status == ST_MULTI   && i_hit_total == HITS_SAT) ||
            (i_status == ST_INVALID))
        else $error("status and hit total disagree");

    // address is zero unless the match is unique
    a_addr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status != ST_UNIQUE |-> i_match_address == '0)
        else $error("match address set without a unique match");

    // the request side only stalls behind a result that is not taken
    a_in_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid && !i_out_ready)
        else $error("request stalled without output backpressure");

endmodule

bind unique_masked_pattern_scanner umps_checker u_umps_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_ready      (i_in.ready),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_status        (o_out.status),
    .i_match_address (o_out.match_address),
    .i_hit_total     (o_out.hit_total)
);
